// ===== src/gpdb_pkg.sv =====
// gpdb_pkg: shared codes and types of the gpio debounce and output probe block
// action codes, event codes, register indexes, result and per-pin state records
// no dependencies
package gpdb_pkg;

    // input action codes
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_CAPTURE = 3'd1,
        ACT_PROBE   = 3'd2,
        ACT_SET     = 3'd3,
        ACT_RELEASE = 3'd4,
        ACT_PING    = 3'd5,
        ACT_REPORT  = 3'd6
    } t_action;

    // result event codes
    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_CHANGED  = 4'd1,
        EV_PSTART   = 4'd2,
        EV_BAD_PIN  = 4'd3,
        EV_PDONE    = 4'd4,
        EV_SET      = 4'd5,
        EV_RELEASED = 4'd6,
        EV_PONG     = 4'd7,
        EV_REPORTED = 4'd8
    } t_event;

    // configuration register indexes
    localparam logic [1:0] CFG_SCAN_EN    = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_INT = 2'd1;
    localparam logic [1:0] CFG_TOGGLE_INT = 2'd2;
    localparam logic [1:0] CFG_TOGGLE_LIM = 2'd3;

    // repeat count thresholds
    localparam logic [1:0] REP_MAX    = 2'd3;
    localparam logic [1:0] REP_COMMIT = 2'd2;
    localparam logic [1:0] REP_FIRST  = 2'd1;

    // one result transaction
    typedef struct packed {
        logic [3:0] ev;
        logic [3:0] pin;
        logic       lvl;
        logic       last;
        logic [7:0] stable;
        logic [7:0] drv_en;
        logic [7:0] drv_val;
    } t_result;

    // debounce state of one pin
    typedef struct packed {
        logic       last;
        logic [1:0] rep;
        logic       stable;
    } t_pin_state;

endpackage

// ===== src/gpio_debounce_and_output_probe.sv =====
// gpio_debounce_and_output_probe: top level, sequencer, pin state and timers
// depends on gpdb_pkg, gpdb_debounce_unit, gpdb_out_reg
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_action i_pin i_level i_active_high i_pin_levels
// result    out        o_valid / i_ready    o_event_res o_event_pin o_event_level o_last
//                                           o_stable_bits o_drive_enable o_drive_value
// config    in         i_cfg_we             i_cfg_idx i_cfg_data
//
// a sampling tick first passes the pins through the debounce unit, one pin per cycle,
// then the result scan visits one pin per cycle while no changed pin waits for the output
// stage; other ticks skip the debounce pass; every other action emits one result from S_ONE
// o_ready is high only while the sequencer is idle; a result stall holds the scan
// reset (synchronous, active low) sets the non-payload registers to their documented values
module gpio_debounce_and_output_probe #(
    parameter int NUM_PINS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_pin,
    input  logic        i_level,
    input  logic        i_active_high,
    input  logic [7:0]  i_pin_levels,
    // result transactions
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_event_res,
    output logic [3:0]  o_event_pin,
    output logic        o_event_level,
    output logic        o_last,
    output logic [7:0]  o_stable_bits,
    output logic [7:0]  o_drive_enable,
    output logic [7:0]  o_drive_value,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import gpdb_pkg::*;

    localparam int         PIN_COUNT = (NUM_PINS < 8) ? NUM_PINS : 8;
    localparam logic [7:0] PIN_MASK  = 8'((1 << PIN_COUNT) - 1);
    localparam logic [2:0] IDX_END   = 3'(PIN_COUNT - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TICK   = 7'b0000010,
        S_SAMPLE = 7'b0000100,
        S_PROBE  = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_ONE    = 7'b1000000
    } t_state;

    // configuration
    logic        r_scan_en;
    logic [15:0] r_sample_int;
    logic [15:0] r_toggle_int;
    logic [7:0]  r_toggle_lim;

    // architectural state
    logic [7:0]  r_stable, n_stable;
    logic [7:0]  r_last, n_last;
    logic [1:0]  r_rep [8];
    logic [1:0]  n_rep [8];
    logic [15:0] r_sample_timer, n_sample_timer;
    logic        r_probe_busy, n_probe_busy;
    logic [2:0]  r_probe_pin, n_probe_pin;
    logic        r_probe_phase, n_probe_phase;
    logic        r_probe_pol, n_probe_pol;
    logic [7:0]  r_toggles, n_toggles;
    logic [15:0] r_probe_timer, n_probe_timer;
    logic [7:0]  r_out_en, n_out_en;
    logic [7:0]  r_out_val, n_out_val;

    // sequencer
    t_state      r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_chg, n_chg;
    logic        r_pdone, n_pdone;
    logic [2:0]  r_done_pin, n_done_pin;

    // item and single-event payload
    logic [7:0]  r_levels;
    logic [3:0]  r_ev_code, n_ev_code;
    logic [3:0]  r_ev_pin, n_ev_pin;
    logic        r_ev_level, n_ev_level;

    // datapath helpers
    t_pin_state  dbu_cur, dbu_nxt;
    logic        dbu_changed;
    logic [7:0]  probe_mask, pin_mask, rel_en, rel_val;
    logic [7:0]  tmp_en, tmp_val, tmp_chg;
    logic [7:0]  tog_next;
    logic        pin_good, tog_phase, tog_bit;
    logic        ld_valid, out_free, accept;
    t_result     ld_data, out_data;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // shared debounce unit, fed from the scan index
    assign dbu_cur.last   = r_last[r_idx];
    assign dbu_cur.rep    = r_rep[r_idx];
    assign dbu_cur.stable = r_stable[r_idx];

    gpdb_debounce_unit u_dbu (
        .i_sample  (r_levels[r_idx]),
        .i_cur     (dbu_cur),
        .o_nxt     (dbu_nxt),
        .o_changed (dbu_changed)
    );

    // masks and the drive state after releasing a running probe
    assign probe_mask = 8'd1 << r_probe_pin;
    assign pin_mask   = 8'd1 << i_pin[2:0];
    assign pin_good   = (i_pin < 4'(PIN_COUNT));
    assign rel_en     = r_probe_busy ? (r_out_en & ~probe_mask) : r_out_en;
    assign rel_val    = r_probe_busy ? (r_out_val & ~probe_mask) : r_out_val;
    assign tog_next   = r_toggles + 8'd1;
    assign tog_phase  = ~r_probe_phase;
    assign tog_bit    = r_probe_pol ? tog_phase : ~tog_phase;

    // sequencer and next state
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_chg          = r_chg;
        n_pdone        = r_pdone;
        n_done_pin     = r_done_pin;
        n_stable       = r_stable;
        n_last         = r_last;
        n_rep          = r_rep;
        n_sample_timer = r_sample_timer;
        n_probe_busy   = r_probe_busy;
        n_probe_pin    = r_probe_pin;
        n_probe_phase  = r_probe_phase;
        n_probe_pol    = r_probe_pol;
        n_toggles      = r_toggles;
        n_probe_timer  = r_probe_timer;
        n_out_en       = r_out_en;
        n_out_val      = r_out_val;
        n_ev_code      = r_ev_code;
        n_ev_pin       = r_ev_pin;
        n_ev_level     = r_ev_level;
        tmp_en         = r_out_en;
        tmp_val        = r_out_val;
        tmp_chg        = r_chg;
        ld_valid       = 1'b0;
        ld_data.ev     = EV_NONE;
        ld_data.pin    = 4'd0;
        ld_data.lvl    = 1'b0;
        ld_data.last   = 1'b1;
        ld_data.stable = r_stable;
        ld_data.drv_en = r_out_en;
        ld_data.drv_val = r_out_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ev_code  = EV_NONE;
                    n_ev_pin   = 4'd0;
                    n_ev_level = 1'b0;
                    n_state    = S_ONE;
                    case (i_action)
                        ACT_TICK: begin
                            if (r_sample_timer != 16'hFFFF) begin
                                n_sample_timer = r_sample_timer + 16'd1;
                            end
                            if (r_probe_timer != 16'hFFFF) begin
                                n_probe_timer = r_probe_timer + 16'd1;
                            end
                            n_chg   = '0;
                            n_pdone = 1'b0;
                            n_state = S_TICK;
                        end
                        ACT_CAPTURE: begin
                            n_stable = (r_stable & ~PIN_MASK) | (i_pin_levels & PIN_MASK);
                            n_last   = (r_last & ~PIN_MASK) | (i_pin_levels & PIN_MASK);
                            for (int i = 0; i < PIN_COUNT; i++) begin
                                n_rep[i] = 2'd0;
                            end
                        end
                        ACT_PROBE, ACT_SET: begin
                            // any running probe is released first
                            n_probe_busy  = 1'b0;
                            n_probe_phase = 1'b0;
                            n_toggles     = 8'd0;
                            n_out_en      = rel_en;
                            n_out_val     = rel_val;
                            n_ev_pin      = i_pin;
                            if (!pin_good) begin
                                n_ev_code = EV_BAD_PIN;
                            end else if (i_action == ACT_PROBE) begin
                                n_probe_busy  = 1'b1;
                                n_probe_pin   = i_pin[2:0];
                                n_probe_pol   = i_active_high;
                                n_probe_timer = 16'd0;
                                n_out_en      = rel_en | pin_mask;
                                n_out_val     = i_active_high ? (rel_val & ~pin_mask)
                                                              : (rel_val | pin_mask);
                                n_ev_code     = EV_PSTART;
                            end else begin
                                n_out_en   = rel_en | pin_mask;
                                n_out_val  = (i_level ^ ~i_active_high) ? (rel_val | pin_mask)
                                                                        : (rel_val & ~pin_mask);
                                n_ev_code  = EV_SET;
                                n_ev_level = i_level;
                            end
                        end
                        ACT_RELEASE: begin
                            n_probe_busy  = 1'b0;
                            n_probe_phase = 1'b0;
                            n_toggles     = 8'd0;
                            n_out_en      = rel_en;
                            n_out_val     = rel_val;
                            n_ev_code     = EV_RELEASED;
                        end
                        ACT_PING: begin
                            n_ev_code = EV_PONG;
                        end
                        ACT_REPORT: begin
                            n_ev_code = EV_REPORTED;
                        end
                        default: begin
                            n_ev_code = EV_NONE;
                        end
                    endcase
                end
            end
            // decide whether this tick samples
            S_TICK: begin
                n_idx = 3'd0;
                if (r_scan_en && r_sample_timer >= r_sample_int) begin
                    n_sample_timer = 16'd0;
                    n_state        = S_SAMPLE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            // one pin per cycle through the debounce unit
            S_SAMPLE: begin
                if (!(r_probe_busy && r_probe_pin == r_idx)) begin
                    n_out_en[r_idx]  = 1'b0;
                    n_out_val[r_idx] = 1'b0;
                    n_last[r_idx]    = dbu_nxt.last;
                    n_rep[r_idx]     = dbu_nxt.rep;
                    n_stable[r_idx]  = dbu_nxt.stable;
                    n_chg[r_idx]     = dbu_changed;
                end
                if (r_idx == IDX_END) begin
                    n_state = S_PROBE;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            // probe toggle step
            S_PROBE: begin
                n_idx   = 3'd0;
                n_state = S_EMIT;
                if (r_probe_busy && r_probe_timer >= r_toggle_int) begin
                    n_probe_timer = 16'd0;
                    n_probe_phase = tog_phase;
                    n_toggles     = tog_next;
                    tmp_en        = r_out_en | probe_mask;
                    tmp_val       = tog_bit ? (r_out_val | probe_mask)
                                            : (r_out_val & ~probe_mask);
                    n_out_en      = tmp_en;
                    n_out_val     = tmp_val;
                    if (tog_next >= r_toggle_lim) begin
                        n_out_en      = tmp_en & ~probe_mask;
                        n_out_val     = tmp_val & ~probe_mask;
                        n_probe_busy  = 1'b0;
                        n_probe_phase = 1'b0;
                        n_toggles     = 8'd0;
                        n_probe_pol   = 1'b1;
                        n_done_pin    = r_probe_pin;
                        // a full set of change events leaves no room for this one
                        n_pdone       = (r_chg != 8'hFF);
                    end
                end
            end
            // scan the change mask, one pin per cycle unless a changed pin waits for the output stage
            S_EMIT: begin
                tmp_chg        = r_chg;
                tmp_chg[r_idx] = 1'b0;
                ld_data.ev     = EV_CHANGED;
                ld_data.pin    = {1'b0, r_idx};
                ld_data.lvl    = r_stable[r_idx];
                ld_data.last   = (tmp_chg == 8'd0) && !r_pdone;
                if (!r_chg[r_idx] || out_free) begin
                    if (r_chg[r_idx]) begin
                        ld_valid = 1'b1;
                        n_chg    = tmp_chg;
                    end
                    if (r_idx == IDX_END) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            // trailing probe done event
            S_DONE: begin
                ld_data.ev  = EV_PDONE;
                ld_data.pin = {1'b0, r_done_pin};
                if (!r_pdone) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    ld_valid = 1'b1;
                    n_pdone  = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            // single result of a non-tick action
            S_ONE: begin
                ld_data.ev  = r_ev_code;
                ld_data.pin = r_ev_pin;
                ld_data.lvl = r_ev_level;
                if (out_free) begin
                    ld_valid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= 3'd0;
            r_chg          <= 8'd0;
            r_pdone        <= 1'b0;
            r_done_pin     <= 3'd0;
            r_stable       <= 8'd0;
            r_last         <= 8'd0;
            r_rep          <= '{default: 2'd0};
            r_sample_timer <= 16'd0;
            r_probe_busy   <= 1'b0;
            r_probe_pin    <= 3'd0;
            r_probe_phase  <= 1'b0;
            r_probe_pol    <= 1'b1;
            r_toggles      <= 8'd0;
            r_probe_timer  <= 16'd0;
            r_out_en       <= 8'd0;
            r_out_val      <= 8'd0;
        end else begin
            r_state        <= n_state;
            r_idx          <= n_idx;
            r_chg          <= n_chg;
            r_pdone        <= n_pdone;
            r_done_pin     <= n_done_pin;
            r_stable       <= n_stable;
            r_last         <= n_last;
            r_rep          <= n_rep;
            r_sample_timer <= n_sample_timer;
            r_probe_busy   <= n_probe_busy;
            r_probe_pin    <= n_probe_pin;
            r_probe_phase  <= n_probe_phase;
            r_probe_pol    <= n_probe_pol;
            r_toggles      <= n_toggles;
            r_probe_timer  <= n_probe_timer;
            r_out_en       <= n_out_en;
            r_out_val      <= n_out_val;
        end
    end

    // item payload and single-event fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_levels <= i_pin_levels;
        end
        r_ev_code  <= n_ev_code;
        r_ev_pin   <= n_ev_pin;
        r_ev_level <= n_ev_level;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en    <= 1'b1;
            r_sample_int <= 16'd20;
            r_toggle_int <= 16'd500;
            r_toggle_lim <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCAN_EN:    r_scan_en    <= i_cfg_data[0];
                CFG_SAMPLE_INT: r_sample_int <= i_cfg_data;
                CFG_TOGGLE_INT: r_toggle_int <= i_cfg_data;
                CFG_TOGGLE_LIM: r_toggle_lim <= i_cfg_data[7:0];
                default:        r_scan_en    <= r_scan_en;
            endcase
        end
    end

    // result output stage
    gpdb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld_valid),
        .i_data  (ld_data),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_event_res    = out_data.ev;
    assign o_event_pin    = out_data.pin;
    assign o_event_level  = out_data.lvl;
    assign o_last         = out_data.last;
    assign o_stable_bits  = out_data.stable;
    assign o_drive_enable = out_data.drv_en;
    assign o_drive_value  = out_data.drv_val;

    // a running probe always drives its pin
    a_probe_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe_busy |-> r_out_en[r_probe_pin])
        else $error("probe running on an undriven pin");

    // pins beyond the bank never hold a stable level or a drive
    a_bank_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_stable | r_out_en | r_out_val) & ~PIN_MASK) == 8'd0)
        else $error("state set on a pin outside the bank");

    // an accepted transaction keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("input accepted in consecutive cycles");

    // the output stage is loaded only when it has room
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_valid |-> out_free)
        else $error("result loaded into a full output stage");

endmodule

// ===== src/gpdb_debounce_unit.sv =====
// gpdb_debounce_unit: shared debounce step, applied to one pin per cycle
// depends on gpdb_pkg
module gpdb_debounce_unit (
    input  logic                  i_sample,
    input  gpdb_pkg::t_pin_state  i_cur,
    output gpdb_pkg::t_pin_state  o_nxt,
    output logic                  o_changed
);
    import gpdb_pkg::*;

    always_comb begin
        o_nxt     = i_cur;
        o_changed = 1'b0;
        // repeat count, saturating, restarts on a new level
        if (i_sample == i_cur.last) begin
            if (i_cur.rep < REP_MAX) begin
                o_nxt.rep = i_cur.rep + 2'd1;
            end
        end else begin
            o_nxt.last = i_sample;
            o_nxt.rep  = REP_FIRST;
        end
        // commit a new stable level
        if (o_nxt.rep >= REP_COMMIT && i_cur.stable != o_nxt.last) begin
            o_nxt.stable = o_nxt.last;
            o_changed    = 1'b1;
        end
    end

endmodule

// ===== src/gpdb_out_reg.sv =====
// gpdb_out_reg: output register stage for result transactions
// depends on gpdb_pkg
module gpdb_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  gpdb_pkg::t_result  i_data,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output gpdb_pkg::t_result  o_data
);
    import gpdb_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== bench/gpio_debounce_and_output_probe_tb.sv =====
`timescale 1ns / 1ps
// gpio_debounce_and_output_probe_tb: self-checking bench for the debounce and probe block
// a directed table and random transactions, checked against an in-bench model of the pins
// depends on gpdb_pkg and gpio_debounce_and_output_probe
module gpio_debounce_and_output_probe_tb;
    import gpdb_pkg::*;

    localparam int PIN_COUNT    = 8;
    localparam int MAX_EVENTS   = 8;
    localparam int DRAIN_CYCLES = 48;
    localparam int QUIET_LIMIT  = 3000;
    localparam logic [2:0] ACT_UNKNOWN = 3'd7;

    // one input transaction, with the event typed in where it is obvious
    typedef struct {
        logic [2:0] action;
        logic [3:0] pin;
        logic       level;
        logic       ah;
        logic [7:0] levels;
        logic       known;
        logic [3:0] k_ev;
        logic [3:0] k_pin;
        logic       k_lvl;
    } t_stim;

    // one register setting and how many random transactions run under it
    typedef struct {
        logic        scan;
        logic [15:0] smp_int;
        logic [15:0] tgl_int;
        logic [7:0]  tgl_lim;
        int          items;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action      = ACT_TICK;
    logic [3:0]  i_pin         = 4'd0;
    logic        i_level       = 1'b0;
    logic        i_active_high = 1'b0;
    logic [7:0]  i_pin_levels  = 8'h00;
    logic        o_valid;
    logic        i_ready       = 1'b1;
    logic [3:0]  o_event_res;
    logic [3:0]  o_event_pin;
    logic        o_event_level;
    logic        o_last;
    logic [7:0]  o_stable_bits;
    logic [7:0]  o_drive_enable;
    logic [7:0]  o_drive_value;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = CFG_SCAN_EN;
    logic [15:0] i_cfg_data    = 16'd0;

    gpio_debounce_and_output_probe #(
        .NUM_PINS(PIN_COUNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_pin          (i_pin),
        .i_level        (i_level),
        .i_active_high  (i_active_high),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_res    (o_event_res),
        .o_event_pin    (o_event_pin),
        .o_event_level  (o_event_level),
        .o_last         (o_last),
        .o_stable_bits  (o_stable_bits),
        .o_drive_enable (o_drive_enable),
        .o_drive_value  (o_drive_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // bench copy of the registers, at their reset values
    logic        cfg_scan    = 1'b1;
    logic [15:0] cfg_smp_int = 16'd20;
    logic [15:0] cfg_tgl_int = 16'd500;
    logic [7:0]  cfg_tgl_lim = 8'd10;

    // bench copy of the pin state
    logic [7:0]  pin_stable = 8'h00;
    logic [7:0]  pin_last   = 8'h00;
    logic [1:0]  pin_rep [PIN_COUNT] = '{default: 2'd0};
    logic [15:0] smp_timer  = 16'd0;
    logic [15:0] prb_timer  = 16'd0;
    logic        prb_busy   = 1'b0;
    logic [3:0]  prb_pin    = 4'd0;
    logic        prb_phase  = 1'b0;
    logic        prb_pol    = 1'b1;
    logic [7:0]  prb_count  = 8'd0;
    logic [7:0]  drv_en     = 8'h00;
    logic [7:0]  drv_val    = 8'h00;

    t_result     event_buf [MAX_EVENTS];
    int          event_cnt;
    t_result     pending_events [$];
    int          event_errors = 0;

    bit          calm       = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [7:0]  line_levels = 8'h00;

    // pin drive helpers
    task automatic undrive_pin(input logic [2:0] idx);
        drv_en[idx]  = 1'b0;
        drv_val[idx] = 1'b0;
    endtask

    task automatic drive_pin(input logic [2:0] idx, input logic high);
        drv_en[idx]  = 1'b1;
        drv_val[idx] = high;
    endtask

    task automatic drop_probe();
        if (prb_busy)
            undrive_pin(prb_pin[2:0]);
        prb_busy  = 1'b0;
        prb_phase = 1'b0;
        prb_count = 8'd0;
    endtask

    task automatic add_event(input logic [3:0] ev, input logic [3:0] pin, input logic lvl);
        if (event_cnt < MAX_EVENTS) begin
            event_buf[event_cnt]     = '0;
            event_buf[event_cnt].ev  = ev;
            event_buf[event_cnt].pin = pin;
            event_buf[event_cnt].lvl = lvl;
            event_cnt++;
        end
    endtask

    // work out the event records of one accepted transaction and queue them
    task automatic gpio_next_events(input t_stim s);
        int         i;
        logic       lv;
        logic [3:0] done_pin;
        event_cnt = 0;
        case (s.action)
            ACT_TICK: begin
                if (smp_timer != 16'hFFFF)
                    smp_timer++;
                if (prb_timer != 16'hFFFF)
                    prb_timer++;
                // sampling pass, skipping the probed pin
                if (cfg_scan && smp_timer >= cfg_smp_int) begin
                    smp_timer = 16'd0;
                    for (i = 0; i < PIN_COUNT; i++) begin
                        if (!(prb_busy && prb_pin == i)) begin
                            undrive_pin(i[2:0]);
                            lv = s.levels[i];
                            if (lv == pin_last[i]) begin
                                if (pin_rep[i] < REP_MAX)
                                    pin_rep[i]++;
                            end else begin
                                pin_last[i] = lv;
                                pin_rep[i]  = REP_FIRST;
                            end
                            if (pin_rep[i] >= REP_COMMIT && pin_stable[i] != pin_last[i]) begin
                                pin_stable[i] = pin_last[i];
                                add_event(EV_CHANGED, i[3:0], pin_stable[i]);
                            end
                        end
                    end
                end
                // probe toggle after sampling
                if (prb_busy && prb_timer >= cfg_tgl_int) begin
                    prb_timer = 16'd0;
                    prb_phase = ~prb_phase;
                    drive_pin(prb_pin[2:0], prb_pol ? prb_phase : ~prb_phase);
                    prb_count = prb_count + 8'd1;
                    if (prb_count >= cfg_tgl_lim) begin
                        done_pin = prb_pin;
                        drop_probe();
                        prb_pol = 1'b1;
                        add_event(EV_PDONE, done_pin, 1'b0);
                    end
                end
            end
            ACT_CAPTURE: begin
                pin_stable = s.levels;
                pin_last   = s.levels;
                for (i = 0; i < PIN_COUNT; i++)
                    pin_rep[i] = 2'd0;
                add_event(EV_NONE, 4'd0, 1'b0);
            end
            ACT_PROBE: begin
                drop_probe();
                if (s.pin >= PIN_COUNT) begin
                    add_event(EV_BAD_PIN, s.pin, 1'b0);
                end else begin
                    prb_busy  = 1'b1;
                    prb_pin   = s.pin;
                    prb_pol   = s.ah;
                    prb_phase = 1'b0;
                    prb_count = 8'd0;
                    prb_timer = 16'd0;
                    drive_pin(s.pin[2:0], ~s.ah);
                    add_event(EV_PSTART, s.pin, 1'b0);
                end
            end
            ACT_SET: begin
                drop_probe();
                if (s.pin >= PIN_COUNT) begin
                    add_event(EV_BAD_PIN, s.pin, 1'b0);
                end else begin
                    drive_pin(s.pin[2:0], s.ah ? s.level : ~s.level);
                    add_event(EV_SET, s.pin, s.level);
                end
            end
            ACT_RELEASE: begin
                drop_probe();
                add_event(EV_RELEASED, 4'd0, 1'b0);
            end
            ACT_PING:   add_event(EV_PONG, 4'd0, 1'b0);
            ACT_REPORT: add_event(EV_REPORTED, 4'd0, 1'b0);
            default:    add_event(EV_NONE, 4'd0, 1'b0);
        endcase
        // typed-in event for the obvious rows of the table
        if (s.known && event_cnt > 0) begin
            event_buf[0].ev  = s.k_ev;
            event_buf[0].pin = s.k_pin;
            event_buf[0].lvl = s.k_lvl;
        end
        for (i = 0; i < event_cnt; i++) begin
            event_buf[i].last    = (i == event_cnt - 1);
            event_buf[i].stable  = pin_stable;
            event_buf[i].drv_en  = drv_en;
            event_buf[i].drv_val = drv_val;
            pending_events.push_back(event_buf[i]);
        end
    endtask

    // one table row
    function automatic t_stim row(input logic [2:0] a, input logic [3:0] p, input logic lv,
                                  input logic ah, input logic [7:0] levels, input logic known,
                                  input logic [3:0] kev, input logic [3:0] kpin,
                                  input logic klvl);
        t_stim s;
        s.action = a;
        s.pin    = p;
        s.level  = lv;
        s.ah     = ah;
        s.levels = levels;
        s.known  = known;
        s.k_ev   = kev;
        s.k_pin  = kpin;
        s.k_lvl  = klvl;
        return s;
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random transaction; ticks mostly see steady lines so the debounce commits
    function automatic t_stim rand_item();
        t_stim s;
        int    r;
        r        = $urandom_range(0, 99);
        s        = row(ACT_TICK, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, EV_NONE, 4'd0, 1'b0);
        s.pin    = 4'($urandom_range(0, 15));
        s.level  = 1'($urandom_range(0, 1));
        s.ah     = 1'($urandom_range(0, 1));
        s.levels = 8'($urandom_range(0, 255));
        if (r < 58) begin
            if ($urandom_range(0, 99) < 20)
                line_levels = line_levels ^ (8'd1 << $urandom_range(0, 7));
            else if ($urandom_range(0, 99) < 5)
                line_levels = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) >= 8)
                s.levels = line_levels;
        end else if (r < 67) begin
            s.action = ACT_PROBE;
            s.pin    = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 7))
                                                   : 4'($urandom_range(8, 15));
        end else if (r < 76) begin
            s.action = ACT_SET;
            s.pin    = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 7))
                                                   : 4'($urandom_range(8, 15));
        end else if (r < 81) begin
            s.action = ACT_RELEASE;
        end else if (r < 85) begin
            s.action = ACT_CAPTURE;
        end else if (r < 90) begin
            s.action = ACT_PING;
        end else if (r < 95) begin
            s.action = ACT_REPORT;
        end else begin
            s.action = ACT_UNKNOWN;
        end
        return s;
    endfunction

    // present one input transaction and wait for it to be taken
    task automatic send_item(input t_stim s);
        int gap;
        i_valid       <= 1'b1;
        i_action      <= s.action;
        i_pin         <= s.pin;
        i_level       <= s.level;
        i_active_high <= s.ah;
        i_pin_levels  <= s.levels;
        do @(posedge i_clk); while (!o_ready);
        gpio_next_events(s);
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write, one strobe cycle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SCAN_EN:    cfg_scan    = val[0];
            CFG_SAMPLE_INT: cfg_smp_int = val;
            CFG_TOGGLE_INT: cfg_tgl_int = val;
            CFG_TOGGLE_LIM: cfg_tgl_lim = val[7:0];
            default: ;
        endcase
    endtask

    // let the block go idle, then load a new setting
    task automatic apply_settings(input t_phase ph);
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        // a tick without events may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_SCAN_EN, {15'd0, ph.scan});
        write_reg(CFG_SAMPLE_INT, ph.smp_int);
        write_reg(CFG_TOGGLE_INT, ph.tgl_int);
        write_reg(CFG_TOGGLE_LIM, {8'd0, ph.tgl_lim});
        calm <= ($urandom_range(0, 3) == 0);
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            i_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // cycles with no transaction on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("gpio_debounce_and_output_probe test failed");
        $finish;
    end

    // compare each result transaction with the oldest expected record
    t_result seen;
    t_result wanted;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_event_res, o_event_pin, o_event_level, o_last,
                    o_stable_bits, o_drive_enable, o_drive_value};
            if (pending_events.size() == 0) begin
                if (event_errors < 10)
                    $display("unexpected event record: ev %0d pin %0d", seen.ev, seen.pin);
                event_errors++;
            end else begin
                wanted = pending_events.pop_front();
                if (seen !== wanted) begin
                    if (event_errors < 10) begin
                        $write("event mismatch (got/exp): ev %0d/%0d pin %0d/%0d lvl %0d/%0d",
                               seen.ev, wanted.ev, seen.pin, wanted.pin, seen.lvl, wanted.lvl);
                        $display(" last %0d/%0d stable %h/%h en %h/%h val %h/%h",
                                 seen.last, wanted.last, seen.stable, wanted.stable,
                                 seen.drv_en, wanted.drv_en, seen.drv_val, wanted.drv_val);
                    end
                    event_errors++;
                end
            end
        end
    end

    t_stim  dir_rows [$];
    t_phase plan [$];
    t_phase ph;
    int     p;
    int     k;

    initial begin
        // directed table: reset behaviour, bad pins, every action, probe to completion
        dir_rows.push_back(row(ACT_PING,    4'd0,  1'b0, 1'b0, 8'h00, 1'b1, EV_PONG,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_REPORT,  4'd15, 1'b1, 1'b1, 8'hFF, 1'b1, EV_REPORTED, 4'd0, 1'b0));
        dir_rows.push_back(row(ACT_UNKNOWN, 4'd9,  1'b1, 1'b0, 8'h5A, 1'b1, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_CAPTURE, 4'd0,  1'b0, 1'b0, 8'hFF, 1'b1, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_CAPTURE, 4'd0,  1'b0, 1'b0, 8'h00, 1'b1, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'hFF, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'hFF, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'h00, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'h00, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_SET,     4'd15, 1'b1, 1'b1, 8'h00, 1'b1, EV_BAD_PIN,  4'd15, 1'b0));
        dir_rows.push_back(row(ACT_PROBE,   4'd8,  1'b0, 1'b1, 8'h00, 1'b1, EV_BAD_PIN,  4'd8, 1'b0));
        dir_rows.push_back(row(ACT_SET,     4'd0,  1'b1, 1'b1, 8'h00, 1'b1, EV_SET,      4'd0, 1'b1));
        dir_rows.push_back(row(ACT_SET,     4'd7,  1'b0, 1'b0, 8'h00, 1'b1, EV_SET,      4'd7, 1'b0));
        dir_rows.push_back(row(ACT_PROBE,   4'd3,  1'b0, 1'b1, 8'h00, 1'b1, EV_PSTART,   4'd3, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'h00, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'h55, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_PROBE,   4'd5,  1'b0, 1'b0, 8'h55, 1'b1, EV_PSTART,   4'd5, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'h55, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_SET,     4'd5,  1'b1, 1'b1, 8'h55, 1'b1, EV_SET,      4'd5, 1'b1));
        dir_rows.push_back(row(ACT_PROBE,   4'd6,  1'b0, 1'b1, 8'hAA, 1'b1, EV_PSTART,   4'd6, 1'b0));
        dir_rows.push_back(row(ACT_RELEASE, 4'd0,  1'b0, 1'b0, 8'hAA, 1'b1, EV_RELEASED, 4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'hAA, 1'b0, EV_NONE,     4'd0, 1'b0));
        dir_rows.push_back(row(ACT_TICK,    4'd0,  1'b0, 1'b0, 8'hAA, 1'b0, EV_NONE,     4'd0, 1'b0));

        // register settings for the random part: small, zero, extreme and random
        plan.push_back('{1'b1, 16'd1,     16'd1,     8'd1,   70});
        plan.push_back('{1'b1, 16'd2,     16'd3,     8'd5,   70});
        plan.push_back('{1'b0, 16'd1,     16'd2,     8'd3,   40});
        plan.push_back('{1'b1, 16'd0,     16'd0,     8'd0,   60});
        plan.push_back('{1'b1, 16'd65535, 16'd65535, 8'd255, 30});
        plan.push_back('{1'b1, 16'd3,     16'd1,     8'd255, 60});
        repeat (2) begin
            ph.scan    = 1'b1;
            ph.smp_int = 16'($urandom_range(1, 4));
            ph.tgl_int = 16'($urandom_range(1, 6));
            ph.tgl_lim = 8'($urandom_range(1, 8));
            ph.items   = 40;
            plan.push_back(ph);
        end

        // single reset at the start
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, sampling and toggling on every tick
        apply_settings('{1'b1, 16'd1, 16'd1, 8'd2, 0});
        for (k = 0; k < dir_rows.size(); k++)
            send_item(dir_rows[k]);

        // random part
        for (p = 0; p < plan.size(); p++) begin
            apply_settings(plan[p]);
            repeat (plan[p].items) send_item(rand_item());
        end

        // let the last events out
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (event_errors == 0)
            $display("gpio_debounce_and_output_probe test passed");
        else
            $display("gpio_debounce_and_output_probe test failed");
        $finish;
    end

endmodule
